FILE: sv/ssk_pkg.sv
// ----------------------------------------------------------------------------
// Stirling second-kind package
// Shared types and constants for the partition count engine.
// ----------------------------------------------------------------------------
package ssk_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned FIELD_W = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_TOP,
        S_MUL,
        S_ADD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load_top;
        logic zero_top;
        logic mul;
        logic add;
    } t_mac_ctrl;

endpackage

FILE: sv/ssk_row_mem.sv
// ----------------------------------------------------------------------------
// Scratch row memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssk_row_mem #(
    parameter int unsigned DEPTH = 26,
    parameter int unsigned AW    = 5
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [ssk_pkg::DATA_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [ssk_pkg::DATA_W-1:0] o_rd_data
);

    logic [ssk_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [ssk_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/ssk_mac_unit.sv
// ----------------------------------------------------------------------------
// Shared multiply-add unit
// Computes j*S(i-1,j) + S(i-1,j-1), one multiply and one add per update.
// ----------------------------------------------------------------------------
module ssk_mac_unit #(
    parameter int unsigned IW = 5
) (
    input  logic                       i_clk,
    input  ssk_pkg::t_mac_ctrl         i_ctrl,
    input  logic [IW-1:0]              i_mult,
    input  logic [ssk_pkg::DATA_W-1:0] i_rd_data,
    output logic [ssk_pkg::DATA_W-1:0] o_sum
);

    logic [ssk_pkg::DATA_W-1:0] r_cur;
    logic [ssk_pkg::DATA_W-1:0] r_prev;
    logic [ssk_pkg::DATA_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_top) begin
            r_cur <= i_ctrl.zero_top ? '0 : i_rd_data;
        end else if (i_ctrl.add) begin
            r_cur <= r_prev;
        end
        if (i_ctrl.mul) begin
            r_prod <= ssk_pkg::DATA_W'(r_cur * ssk_pkg::DATA_W'(i_mult));
            r_prev <= i_rd_data;
        end
    end

    assign o_sum = r_prod + r_prev;

endmodule

FILE: sv/stirling_second_kind_dp.sv
// Requests with k = 0, k > n, or n or k out of range go from idle straight to
// the finish state. Otherwise each row i=1..n updates columns max(1, i-n+k)
// up to min(i,k), highest first. One request at a time; each update steps
// through the MUL and ADD states, sharing the multiply-add unit and the single
// memory read port. Reset clears control state only; the scratch row needs no
// clearing pass.
// ----------------------------------------------------------------------------
// Stirling numbers of the second kind
// Row-by-row recurrence over a scratch row, driven by a small sequencer.
// ----------------------------------------------------------------------------
module stirling_second_kind_dp #(
    parameter int unsigned MAX_N = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ssk_pkg::FIELD_W-1:0] i_set_size,
    input  logic [ssk_pkg::FIELD_W-1:0] i_block_count,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ssk_pkg::DATA_W-1:0]  o_partition_count
);

    localparam int unsigned DEPTH = MAX_N + 1;
    localparam int unsigned IW    = $clog2(DEPTH);

    ssk_pkg::t_state    r_state;
    ssk_pkg::t_state    n_state;
    ssk_pkg::t_mac_ctrl mac_ctrl;

    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [IW-1:0] r_n;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_diff;
    logic [IW-1:0] row_lo;
    logic [IW-1:0] row_hi;
    logic          r_rd_at0;

    logic [ssk_pkg::DATA_W-1:0] r_result;
    logic [ssk_pkg::DATA_W-1:0] r_out_data;
    logic                       r_out_valid;

    logic                       in_accept;
    logic                       out_free;
    logic                       bad_req;
    logic                       rd_en;
    logic [IW-1:0]              rd_addr;
    logic                       wr_en;
    logic [ssk_pkg::DATA_W-1:0] mem_rd_data;
    logic [ssk_pkg::DATA_W-1:0] rd_val;
    logic [ssk_pkg::DATA_W-1:0] mac_sum;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign bad_req   = (i_set_size > ssk_pkg::FIELD_W'(MAX_N))
                    || (i_block_count > ssk_pkg::FIELD_W'(MAX_N))
                    || (i_block_count > i_set_size)
                    || (i_block_count == '0);

    assign row_lo = (r_i > r_diff) ? (r_i - r_diff) : IW'(1);
    assign row_hi = (r_i < r_k) ? r_i : r_k;

    // Column 0 is never stored: S(i-1,0) is 1 only on the first row.
    assign rd_val = r_rd_at0 ? {{(ssk_pkg::DATA_W-1){1'b0}}, (r_i == IW'(1))} : mem_rd_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssk_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = bad_req ? ssk_pkg::S_FIN : ssk_pkg::S_ROW;
                end
            end
            ssk_pkg::S_ROW: n_state = ssk_pkg::S_TOP;
            ssk_pkg::S_TOP: n_state = ssk_pkg::S_MUL;
            ssk_pkg::S_MUL: n_state = ssk_pkg::S_ADD;
            ssk_pkg::S_ADD: begin
                if (r_j == row_lo) begin
                    n_state = (r_i == r_n) ? ssk_pkg::S_FIN : ssk_pkg::S_ROW;
                end else begin
                    n_state = ssk_pkg::S_MUL;
                end
            end
            ssk_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = ssk_pkg::S_IDLE;
                end
            end
            default: n_state = ssk_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        mac_ctrl   = '0;
        unique case (r_state)
            ssk_pkg::S_IDLE: o_in_ready = 1'b1;
            ssk_pkg::S_ROW: begin
                rd_en   = 1'b1;
                rd_addr = row_hi;
            end
            ssk_pkg::S_TOP: begin
                rd_en             = 1'b1;
                rd_addr           = r_j - IW'(1);
                mac_ctrl.load_top = 1'b1;
                mac_ctrl.zero_top = (r_j == r_i);
            end
            ssk_pkg::S_MUL: mac_ctrl.mul = 1'b1;
            ssk_pkg::S_ADD: begin
                wr_en        = 1'b1;
                mac_ctrl.add = 1'b1;
                if (r_j != row_lo) begin
                    rd_en   = 1'b1;
                    rd_addr = r_j - IW'(2);
                end
            end
            ssk_pkg::S_FIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssk_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ssk_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_at0 <= (rd_addr == '0);
        end
        if (r_state == ssk_pkg::S_FIN && out_free) begin
            r_out_data <= r_result;
        end
        unique case (r_state)
            ssk_pkg::S_IDLE: begin
                if (in_accept) begin
                    r_n      <= IW'(i_set_size);
                    r_k      <= IW'(i_block_count);
                    r_diff   <= IW'(i_set_size - i_block_count);
                    r_i      <= IW'(1);
                    r_result <= {{(ssk_pkg::DATA_W-1){1'b0}},
                                 (i_set_size == '0) && (i_block_count == '0)};
                end
            end
            ssk_pkg::S_ROW: r_j <= row_hi;
            ssk_pkg::S_ADD: begin
                if (r_j == row_lo) begin
                    r_i <= r_i + IW'(1);
                    if (r_i == r_n) begin
                        r_result <= mac_sum;
                    end
                end else begin
                    r_j <= r_j - IW'(1);
                end
            end
            default: ;
        endcase
    end

    ssk_row_mem #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_j),
        .i_wr_data (mac_sum),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_rd_data)
    );

    ssk_mac_unit #(
        .IW (IW)
    ) u_mac_unit (
        .i_clk     (i_clk),
        .i_ctrl    (mac_ctrl),
        .i_mult    (r_j),
        .i_rd_data (rd_val),
        .o_sum     (mac_sum)
    );

    assign o_out_valid       = r_out_valid;
    assign o_partition_count = r_out_data;

`ifndef ASSERT_OFF
    a_add_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ssk_pkg::S_ADD |-> (r_j >= row_lo) && (r_j <= row_hi))
        else $error("update index outside row window");

    a_no_col0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_j != '0)
        else $error("write to column zero");

    a_bad_req_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && bad_req |=> r_state == ssk_pkg::S_FIN)
        else $error("degenerate request did not finish at once");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stirling second-kind engine testbench
// Feeds (n, k) requests through a valid/ready driver with random gaps, checks
// every partition count against an in-bench row recurrence, and stalls the
// result side at random, including one long hold that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned SET_MAX     = 25;
    localparam int          N_RANDOM    = 1200;
    localparam int          HOLD_CYCLES = 900;
    localparam int          TAIL_CYCLES = 500;
    localparam int          CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [ssk_pkg::FIELD_W-1:0] n;
        logic [ssk_pkg::FIELD_W-1:0] k;
        int                          gap;
        bit                          drain;
    } t_req;

    logic                        i_clk             = 1'b0;
    logic                        i_rst_n           = 1'b0;
    logic                        i_in_valid        = 1'b0;
    logic [ssk_pkg::FIELD_W-1:0] i_set_size        = '0;
    logic [ssk_pkg::FIELD_W-1:0] i_block_count     = '0;
    logic                        i_out_ready       = 1'b0;
    logic                        o_in_ready;
    logic                        o_out_valid;
    logic [ssk_pkg::DATA_W-1:0]  o_partition_count;

    t_req                       req_pending[$];
    logic [ssk_pkg::DATA_W-1:0] count_expected[$];
    logic [ssk_pkg::DATA_W-1:0] part_row [0:SET_MAX];

    t_req drv_req;
    t_req drv_next;
    bit   drv_loaded;
    int   drv_gap;
    int   rx_stall;
    logic rx_hold;
    int   hold_cnt;
    bit   hold_done;
    int   n_accepted;
    int   n_checked;
    int   n_errors;
    int   n_out_range;
    int   n_k_above_n;
    int   cycle_cnt;

    stirling_second_kind_dp #(
        .MAX_N(SET_MAX)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_set_size       (i_set_size),
        .i_block_count    (i_block_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_partition_count(o_partition_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [ssk_pkg::DATA_W-1:0] partition_count(
        input logic [ssk_pkg::FIELD_W-1:0] n,
        input logic [ssk_pkg::FIELD_W-1:0] k
    );
        int i;
        int j;
        if (n > SET_MAX || k > SET_MAX) begin
            return '0;
        end
        part_row[0] = 64'd1;
        for (j = 1; j <= SET_MAX; j++) begin
            part_row[j] = '0;
        end
        for (i = 1; i <= int'(n); i++) begin
            for (j = i; j >= 1; j--) begin
                part_row[j] = 64'(j) * part_row[j] + part_row[j-1];
            end
            part_row[0] = '0;
        end
        return part_row[k];
    endfunction

    task automatic queue_req(input int n, input int k, input int gap, input bit drain);
        t_req r;
        r.n     = ssk_pkg::FIELD_W'(n);
        r.k     = ssk_pkg::FIELD_W'(k);
        r.gap   = gap;
        r.drain = drain;
        if (n > SET_MAX || k > SET_MAX) begin
            n_out_range++;
        end else if (k > n) begin
            n_k_above_n++;
        end
        req_pending.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin : drv
        bit took;
        bit nv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_loaded = 1'b0;
            drv_gap    = 0;
        end else begin
            took = i_in_valid && o_in_ready;
            nv   = i_in_valid && !took;
            if (took) begin
                count_expected.push_back(partition_count(drv_req.n, drv_req.k));
                n_accepted++;
            end
            if (!nv) begin
                if (!drv_loaded && req_pending.size() > 0) begin
                    drv_next   = req_pending.pop_front();
                    drv_gap    = drv_next.gap;
                    drv_loaded = 1'b1;
                end
                if (drv_loaded) begin
                    if (drv_gap > 0) begin
                        drv_gap--;
                    end else if (!(drv_next.drain && count_expected.size() != 0)) begin
                        drv_req       = drv_next;
                        drv_loaded    = 1'b0;
                        nv            = 1'b1;
                        i_set_size    <= drv_next.n;
                        i_block_count <= drv_next.k;
                    end
                end
            end
            i_in_valid <= nv;
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        logic [ssk_pkg::DATA_W-1:0] exp_count;
        bit                         nr;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (count_expected.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("ERROR: unexpected result %0d", o_partition_count);
                    end
                end else begin
                    exp_count = count_expected.pop_front();
                    if (o_partition_count !== exp_count) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("ERROR: result %0d partition_count expected %0d got %0d",
                                     n_checked, exp_count, o_partition_count);
                        end
                    end
                end
                n_checked++;
                rx_stall = ((n_checked / 128) % 3 == 1) ? 0 : $urandom_range(0, 5);
            end
            if (rx_hold) begin
                nr = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
            i_out_ready <= nr;
        end
    end

    // hold off the result side long enough to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold <= 1'b0;
            hold_cnt  = 0;
            hold_done = 1'b0;
        end else if (!hold_done && n_accepted >= 60) begin
            if (hold_cnt < HOLD_CYCLES) begin
                rx_hold <= 1'b1;
                hold_cnt++;
            end else begin
                rx_hold <= 1'b0;
                hold_done = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, count_expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stim
        int idx;
        int sel;
        int n;
        int k;
        int gap;

        queue_req(0, 0, 0, 0);
        queue_req(0, 1, 0, 0);
        queue_req(1, 0, 0, 0);
        queue_req(1, 1, 0, 0);
        queue_req(2, 1, 1, 0);
        queue_req(2, 2, 0, 0);
        queue_req(3, 2, 0, 0);
        queue_req(5, 0, 2, 0);
        queue_req(4, 9, 0, 0);
        queue_req(0, 25, 0, 0);
        queue_req(25, 0, 0, 0);
        queue_req(25, 1, 3, 0);
        queue_req(25, 25, 0, 0);
        queue_req(25, 24, 0, 0);
        queue_req(25, 12, 0, 0);
        queue_req(25, 13, 0, 1);
        queue_req(24, 12, 0, 0);
        queue_req(10, 5, 0, 0);
        queue_req(25, 31, 0, 0);
        queue_req(31, 0, 0, 0);
        queue_req(26, 26, 0, 0);
        queue_req(31, 31, 0, 0);
        queue_req(30, 2, 0, 0);
        queue_req(3, 26, 0, 0);
        queue_req(21, 10, 0, 0);

        for (idx = 0; idx < N_RANDOM; idx++) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                n = $urandom_range(0, 8);
                k = $urandom_range(0, n + 1);
            end else if (sel < 82) begin
                n = $urandom_range(0, SET_MAX);
                k = $urandom_range(0, SET_MAX);
            end else if (sel < 92) begin
                n = $urandom_range(0, SET_MAX);
                k = (n > 2) ? n - $urandom_range(0, 2) : n;
            end else begin
                n = $urandom_range(0, 31);
                k = $urandom_range(0, 31);
            end
            gap = ((idx / 100) % 2 == 1) ? 0 : $urandom_range(0, 5);
            queue_req(n, k, gap, (idx % 150) == 149);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_pending.size() != 0 || drv_loaded || i_in_valid
               || count_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d out of range, %0d with k above n)",
                 n_accepted, n_out_range, n_k_above_n);
        $display("checked %0d partition counts in %0d cycles, %0d errors",
                 n_checked, cycle_cnt, n_errors);
        if (n_errors == 0 && count_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/ssk_pkg.sv
sv/ssk_row_mem.sv
sv/ssk_mac_unit.sv
sv/stirling_second_kind_dp.sv
test/testbench.sv
